>>> rtl/wavhp_pkg.sv
// Shared types, constants and the header microprogram for the WAV header parser.
package wavhp_pkg;

   localparam int POS_W      = 6;
   localparam int HDR_LEN    = 44;
   localparam int FRAME_W    = 17;
   localparam int DIVIDEND_W = 31;
   localparam int DIVISOR_W  = FRAME_W;

   localparam logic [31:0] TAG_RIFF     = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE     = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT      = 32'h666d_7420;
   localparam logic [31:0] TAG_DATA     = 32'h6461_7461;
   localparam logic [31:0] FMT_SIZE     = 32'd16;
   localparam logic [31:0] FMT_PCM      = 32'd1;
   localparam logic [31:0] MAX_CHANNELS = 32'd8;
   localparam logic [31:0] RATE_LIMIT   = 32'h0010_0000;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_HEADER,
      PH_DATA,
      PH_DIV
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER = 2'd0,
      KIND_DATA   = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ERR_RIFF     = 4'd0,
      ERR_WAVE     = 4'd1,
      ERR_FMT_TAG  = 4'd2,
      ERR_FMT_SIZE = 4'd3,
      ERR_FORMAT   = 4'd4,
      ERR_CHANNELS = 4'd5,
      ERR_RATE     = 4'd6,
      ERR_DATA_TAG = 4'd7,
      ERR_LENGTH   = 4'd8
   } err_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_RIFF,
      OP_WAVE,
      OP_FMT_TAG,
      OP_FMT_SIZE,
      OP_FORMAT,
      OP_CHAN,
      OP_RATE,
      OP_DEPTH,
      OP_DATA_TAG,
      OP_LEN
   } chk_op_type;

   // One control word per header byte.
   typedef struct packed {
      logic       first;
      logic       last;
      logic       big;
      logic [1:0] lane;
      chk_op_type op;
   } ucode_type;

   typedef struct packed {
      logic [7:0] byte_in;
      logic       start_req;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [3:0]  error_code;
      logic [3:0]  channels;
      logic [19:0] rate_hz;
      logic [15:0] bits_per_sample;
      logic [31:0] sample_frames;
      logic [7:0]  data_byte;
      logic        last;
   } rsp_word_type;

   // Header microprogram: each field's start, length, byte order and check.
   function automatic ucode_type ucode_rom(input logic [POS_W-1:0] pos);
      logic [POS_W-1:0] fstart;
      logic [2:0]       flen;
      logic             big;
      chk_op_type       op;
      logic [POS_W-1:0] offset;
      ucode_type        w;
      unique case (pos) inside
         [6'd0:6'd3]: begin
            fstart = 6'd0;  flen = 3'd4; big = 1'b1; op = OP_RIFF;
         end
         [6'd4:6'd7]: begin
            fstart = 6'd4;  flen = 3'd4; big = 1'b0; op = OP_NONE;
         end
         [6'd8:6'd11]: begin
            fstart = 6'd8;  flen = 3'd4; big = 1'b1; op = OP_WAVE;
         end
         [6'd12:6'd15]: begin
            fstart = 6'd12; flen = 3'd4; big = 1'b1; op = OP_FMT_TAG;
         end
         [6'd16:6'd19]: begin
            fstart = 6'd16; flen = 3'd4; big = 1'b0; op = OP_FMT_SIZE;
         end
         [6'd20:6'd21]: begin
            fstart = 6'd20; flen = 3'd2; big = 1'b0; op = OP_FORMAT;
         end
         [6'd22:6'd23]: begin
            fstart = 6'd22; flen = 3'd2; big = 1'b0; op = OP_CHAN;
         end
         [6'd24:6'd27]: begin
            fstart = 6'd24; flen = 3'd4; big = 1'b0; op = OP_RATE;
         end
         [6'd28:6'd31]: begin
            fstart = 6'd28; flen = 3'd4; big = 1'b0; op = OP_NONE;
         end
         [6'd32:6'd33]: begin
            fstart = 6'd32; flen = 3'd2; big = 1'b0; op = OP_NONE;
         end
         [6'd34:6'd35]: begin
            fstart = 6'd34; flen = 3'd2; big = 1'b0; op = OP_DEPTH;
         end
         [6'd36:6'd39]: begin
            fstart = 6'd36; flen = 3'd4; big = 1'b1; op = OP_DATA_TAG;
         end
         [6'd40:6'd43]: begin
            fstart = 6'd40; flen = 3'd4; big = 1'b0; op = OP_LEN;
         end
         default: begin
            fstart = pos;   flen = 3'd1; big = 1'b0; op = OP_NONE;
         end
      endcase
      offset  = pos - fstart;
      w.first = (offset == '0);
      w.last  = (offset == (POS_W'(flen) - POS_W'(1)));
      w.big   = big;
      w.lane  = offset[1:0];
      w.op    = op;
      return w;
   endfunction

endpackage

>>> rtl/wavhp_div.sv
// Restoring divider, one quotient bit per cycle, for the frame count.
module wavhp_div import wavhp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient,
   output logic [DIVISOR_W-1:0]  remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    diff;
   logic                  take;

   always_comb begin
      trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
      diff  = trial - {1'b0, divisor};
      take  = (trial >= {1'b0, divisor});
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = CNT_W'(DIVIDEND_W - 1);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = take ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], take};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

>>> rtl/wav_header_parse_passthrough_unit.sv
// WAV header parser: takes a file one byte per word, checks the 44-byte canonical PCM
// header under a small microprogram indexed by the header byte position, emits one
// header word (or one error word), then passes the data chunk through with the final
// byte marked. Header and data bytes are taken one per cycle while the output queue
// has room. On the last header byte the frame count is computed by a restoring
// divider, one quotient bit per cycle, and input is held until the result is queued.
// A two-word output queue lets input keep flowing while a result waits.
module wav_header_parse_passthrough_unit import wavhp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   phase_type            state_ff, state_in;
   logic [POS_W-1:0]     pos_ff, pos_in;
   logic [31:0]          shift_ff, shift_in;
   logic [3:0]           chan_ff, chan_in;
   logic [19:0]          rate_ff, rate_in;
   logic [15:0]          depth_ff, depth_in;
   logic [FRAME_W-1:0]   frame_ff, frame_in;
   logic [31:0]          remain_ff, remain_in;

   rsp_word_type         fifo_ff [2];
   logic                 wr_ptr_ff, rd_ptr_ff;
   logic [1:0]           count_ff, count_in;

   logic                 req_fire;
   logic                 pop;
   logic                 push;
   logic                 fifo_room;
   rsp_word_type         push_word;

   phase_type            cur_state;
   logic [POS_W-1:0]     cur_pos;
   ucode_type            uc;
   logic [31:0]          base;
   logic [31:0]          shift_new;
   logic                 chk_fail;
   err_type              chk_code;

   logic                 div_start;
   logic                 div_done;
   logic [DIVIDEND_W-1:0] div_quo;
   logic [DIVISOR_W-1:0]  div_rem;

   wavhp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (shift_new[DIVIDEND_W-1:0]),
      .divisor   (frame_ff),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign fifo_room = (count_ff != 2'd2);
   assign req_ready = fifo_room && (state_ff != PH_DIV);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = (count_ff != 2'd0);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   // A start word restarts the parse and is itself header byte zero.
   assign cur_state = req_data.start_req ? PH_HEADER : state_ff;
   assign cur_pos   = req_data.start_req ? '0 : pos_ff;
   assign uc        = ucode_rom(cur_pos);
   assign base      = uc.first ? '0 : shift_ff;
   assign shift_new = uc.big ? {base[23:0], req_data.byte_in}
                             : (base | ({24'b0, req_data.byte_in} << {uc.lane, 3'b000}));

   always_comb begin
      chk_fail = 1'b0;
      chk_code = ERR_RIFF;
      unique case (uc.op)
         OP_NONE, OP_DEPTH: begin
         end
         OP_RIFF: begin
            chk_fail = (shift_new != TAG_RIFF);
            chk_code = ERR_RIFF;
         end
         OP_WAVE: begin
            chk_fail = (shift_new != TAG_WAVE);
            chk_code = ERR_WAVE;
         end
         OP_FMT_TAG: begin
            chk_fail = (shift_new != TAG_FMT);
            chk_code = ERR_FMT_TAG;
         end
         OP_FMT_SIZE: begin
            chk_fail = (shift_new != FMT_SIZE);
            chk_code = ERR_FMT_SIZE;
         end
         OP_FORMAT: begin
            chk_fail = (shift_new != FMT_PCM);
            chk_code = ERR_FORMAT;
         end
         OP_CHAN: begin
            chk_fail = (shift_new == '0) || (shift_new > MAX_CHANNELS);
            chk_code = ERR_CHANNELS;
         end
         OP_RATE: begin
            chk_fail = (shift_new == '0) || (shift_new >= RATE_LIMIT);
            chk_code = ERR_RATE;
         end
         OP_DATA_TAG: begin
            chk_fail = (shift_new != TAG_DATA);
            chk_code = ERR_DATA_TAG;
         end
         OP_LEN: begin
            // The remainder test waits for the divider.
            chk_fail = (shift_new == '0) || shift_new[31] || (frame_ff == '0);
            chk_code = ERR_LENGTH;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      shift_in  = shift_ff;
      chan_in   = chan_ff;
      rate_in   = rate_ff;
      depth_in  = depth_ff;
      frame_in  = frame_ff;
      remain_in = remain_ff;
      push      = 1'b0;
      push_word = '0;
      div_start = 1'b0;
      if (req_fire) begin
         unique case (cur_state)
            PH_IDLE: begin
            end
            PH_HEADER: begin
               state_in = PH_HEADER;
               pos_in   = cur_pos + POS_W'(1);
               shift_in = shift_new;
               if (uc.last && chk_fail) begin
                  push                 = 1'b1;
                  push_word.out_kind   = KIND_ERROR;
                  push_word.error_code = chk_code;
                  state_in             = PH_IDLE;
               end else if (uc.last) begin
                  unique case (uc.op)
                     OP_CHAN: chan_in = shift_new[3:0];
                     OP_RATE: rate_in = shift_new[19:0];
                     OP_DEPTH: begin
                        depth_in = shift_new[15:0];
                        frame_in = FRAME_W'(chan_ff) * FRAME_W'(shift_new[15:3]);
                     end
                     OP_LEN: begin
                        remain_in = shift_new;
                        div_start = 1'b1;
                        state_in  = PH_DIV;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            PH_DATA: begin
               push                = 1'b1;
               push_word.out_kind  = KIND_DATA;
               push_word.data_byte = req_data.byte_in;
               push_word.last      = (remain_ff == 32'd1);
               remain_in           = remain_ff - 32'd1;
               if (remain_ff == 32'd1) begin
                  state_in = PH_IDLE;
               end
            end
            PH_DIV: begin
            end
            default: begin
            end
         endcase
      end else if ((state_ff == PH_DIV) && div_done && fifo_room) begin
         push = 1'b1;
         if (div_rem != '0) begin
            push_word.out_kind   = KIND_ERROR;
            push_word.error_code = ERR_LENGTH;
            state_in             = PH_IDLE;
         end else begin
            push_word.out_kind        = KIND_HEADER;
            push_word.channels        = chan_ff;
            push_word.rate_hz         = rate_ff;
            push_word.bits_per_sample = depth_ff;
            push_word.sample_frames   = {1'b0, div_quo};
            state_in                  = PH_DATA;
         end
      end
   end

   always_comb begin
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= PH_IDLE;
         pos_ff    <= '0;
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pos_ff    <= pos_in;
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_ff ^ push;
         rd_ptr_ff <= rd_ptr_ff ^ pop;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff  <= shift_in;
      chan_ff   <= chan_in;
      rate_ff   <= rate_in;
      depth_ff  <= depth_in;
      frame_ff  <= frame_in;
      remain_ff <= remain_in;
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_word;
      end
   end

   a_no_accept_in_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PH_DIV) |-> !req_ready)
      else $error("input word accepted while the frame count is being computed");

   a_data_count_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PH_DATA) |-> (remain_ff != '0))
      else $error("data phase with no bytes left to pass");

   a_div_enters_wait: assert property (@(posedge clock) disable iff (reset)
      div_start |=> (state_ff == PH_DIV) && !div_done)
      else $error("divider started without the sequencer waiting on it");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> fifo_room)
      else $error("result written into a full output queue");

   a_header_pos_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PH_HEADER) |-> (pos_ff < POS_W'(HDR_LEN)))
      else $error("header position ran past the end of the header");

endmodule
